// ===== design/spgl_pkg.sv =====
`default_nettype none
package spgl_pkg;

  localparam int unsigned GAIN_FRAC_BITS = 15;
  localparam int unsigned CORDIC_STEPS   = 16;
  localparam int unsigned ANG_FRAC       = 30;

  localparam int unsigned PAN_W   = 16;
  localparam int unsigned THR_W   = 15;
  localparam int unsigned BOOST_W = 15;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned CFG_IW  = 2;
  localparam int unsigned CFG_DW  = 15;

  localparam int unsigned XW = 34;
  localparam int unsigned ZW = 33;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] PI_QUARTER_Q30 = 32'd843314857;
  localparam logic signed [XW-1:0] CORDIC_K_Q30 = XW'(652032874);

  localparam logic signed [PAN_W-1:0] PAN_MAX = 16'sd16384;
  localparam logic signed [PAN_W-1:0] PAN_MIN = -16'sd16384;

  localparam logic [CFG_IW-1:0] REG_LAW_MODE  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_CENTER_TH = 2'd1;
  localparam logic [CFG_IW-1:0] REG_CENTER_BO = 2'd2;

  typedef struct packed {
    logic                 cp;
    logic                 boost;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = ZW'(843314857);
      1:       v = ZW'(497837829);
      2:       v = ZW'(263043836);
      3:       v = ZW'(133525159);
      4:       v = ZW'(67021687);
      5:       v = ZW'(33543516);
      6:       v = ZW'(16775851);
      7:       v = ZW'(8388437);
      8:       v = ZW'(4194283);
      9:       v = ZW'(2097149);
      10:      v = ZW'(1048576);
      11:      v = ZW'(524288);
      12:      v = ZW'(262144);
      13:      v = ZW'(131072);
      14:      v = ZW'(65536);
      15:      v = ZW'(32768);
      16:      v = ZW'(16384);
      17:      v = ZW'(8192);
      18:      v = ZW'(4096);
      19:      v = ZW'(2048);
      20:      v = ZW'(1024);
      21:      v = ZW'(512);
      22:      v = ZW'(256);
      23:      v = ZW'(128);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/stereo_pan_gain_law.sv =====
// Stereo pan gain law: one signed Q2.14 pan position in, one left/right gain
// pair (unsigned Q1.15, 32768 = 1.0) out per item.
// Input channel: in_valid_i / in_stall_o with pan_position_i. Output channel:
// out_valid_o / out_stall_i with gain_l_o and gain_r_o. An item moves
// at a clock edge with valid high and stall low.
// Configuration: cfg_valid_i / cfg_ready_o (always ready), cfg_index_i selects
// law mode (0), center threshold (1) or center boost (2); other indexes are
// ignored. Write only while no item is in flight.
// Throughput: one item per cycle while out_stall_i is low. Items pass from
// acceptance to output through the queue read stage, the pipelined CORDIC
// rotator (one stage per step), and the boost multiply and output register
// stages.
// A four-item queue sits between the front end and the CORDIC pipeline; when
// out_stall_i is high while out_valid_o is high the pipeline holds, the queue
// fills, and in_stall_o rises once the queue is full.
// Reset empties the queue and pipeline and sets constant-power mode,
// threshold 0 and boost 1.0.
`default_nettype none
module stereo_pan_gain_law
  import spgl_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic signed [PAN_W-1:0] pan_position_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [GAIN_W-1:0]            gain_l_o,
  output logic [GAIN_W-1:0]            gain_r_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IW-1:0]       cfg_index_i,
  input  wire logic [CFG_DW-1:0]       cfg_data_i
);

  logic                law_mode_q;
  logic [THR_W-1:0]    center_threshold_q;
  logic [BOOST_W-1:0]  center_boost_q;

  item_t               f_item;
  item_t               q_item;
  logic                push;
  logic                pop;
  queue_status_t       q_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      law_mode_q         <= 1'b1;
      center_threshold_q <= '0;
      center_boost_q     <= BOOST_W'(16384);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_LAW_MODE:  law_mode_q         <= cfg_data_i[0];
        REG_CENTER_TH: center_threshold_q <= cfg_data_i[THR_W-1:0];
        REG_CENTER_BO: center_boost_q     <= cfg_data_i[BOOST_W-1:0];
        default: ;
      endcase
    end
  end

  spgl_front u_front (
    .in_valid_i         (in_valid_i),
    .pan_position_i     (pan_position_i),
    .law_mode_i         (law_mode_q),
    .center_threshold_i (center_threshold_q),
    .q_status_i         (q_status),
    .in_stall_o         (in_stall_o),
    .push_o             (push),
    .item_o             (f_item)
  );

  spgl_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (f_item),
    .pop_i    (pop),
    .item_o   (q_item),
    .status_o (q_status)
  );

  spgl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (q_item),
    .q_status_i     (q_status),
    .center_boost_i (center_boost_q),
    .out_stall_i    (out_stall_i),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .gain_l_o       (gain_l_o),
    .gain_r_o       (gain_r_o)
  );

`ifndef NO_ASSERTIONS
  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gain_l_o <= GAIN_W'(32768)) && (gain_r_o <= GAIN_W'(32768)))
    else $error("gain above unity");

  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue both full and empty");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !q_status.empty)
    else $error("input stalled with empty queue");
`endif

endmodule
`default_nettype wire

// ===== design/spgl_front.sv =====
`default_nettype none
module spgl_front
  import spgl_pkg::*;
(
  input  wire logic                    in_valid_i,
  input  wire logic signed [PAN_W-1:0] pan_position_i,
  input  wire logic                    law_mode_i,
  input  wire logic [THR_W-1:0]        center_threshold_i,
  input  wire queue_status_t           q_status_i,
  output logic                         in_stall_o,
  output logic                         push_o,
  output item_t                        item_o
);

  localparam int unsigned LW = PAN_W + GAIN_FRAC_BITS + 1;
  localparam logic [LW-1:0] LIN_ONE = LW'(1) << GAIN_FRAC_BITS;

  logic signed [PAN_W-1:0] pan;
  logic signed [PAN_W:0]   pan_ext;
  logic [PAN_W-1:0]        u;
  logic [PAN_W-1:0]        num_l;
  logic [PAN_W-1:0]        num_r;
  logic [THR_W-1:0]        mag;
  logic [47:0]             prod;
  logic [LW-1:0]           lin_l;
  logic [LW-1:0]           lin_r;

  always_comb begin
    if (pan_position_i > PAN_MAX) begin
      pan = PAN_MAX;
    end else if (pan_position_i < PAN_MIN) begin
      pan = PAN_MIN;
    end else begin
      pan = pan_position_i;
    end
    pan_ext = (PAN_W+1)'(pan);
    u       = PAN_W'(pan_ext + 17'sd16384);
    num_l   = PAN_W'(17'sd16384 - pan_ext);
    num_r   = u;
    mag     = pan[PAN_W-1] ? THR_W'(-pan_ext) : THR_W'(pan_ext);
    prod    = (48'(u) * 48'(PI_QUARTER_Q30) + 48'd8192) >> 14;

    lin_l = ((LW'(num_l) << GAIN_FRAC_BITS) + LW'(16384)) >> 15;
    lin_r = ((LW'(num_r) << GAIN_FRAC_BITS) + LW'(16384)) >> 15;
    if (lin_l > LIN_ONE) lin_l = LIN_ONE;
    if (lin_r > LIN_ONE) lin_r = LIN_ONE;

    item_o.cp    = law_mode_i;
    item_o.boost = law_mode_i && (mag < center_threshold_i);
    if (law_mode_i) begin
      item_o.x = CORDIC_K_Q30;
      item_o.y = '0;
      item_o.z = ZW'(prod[31:0]);
    end else begin
      item_o.x = XW'(lin_l);
      item_o.y = XW'(lin_r);
      item_o.z = '0;
    end
  end

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

endmodule
`default_nettype wire

// ===== design/spgl_queue.sv =====
`default_nettype none
module spgl_queue
  import spgl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire item_t    item_i,
  input  wire logic     pop_i,
  output item_t         item_o,
  output queue_status_t status_o
);

  item_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_q, wr_d;
  logic [QUEUE_AW-1:0]   rd_q, rd_d;
  logic [QUEUE_AW:0]     cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  assign status_o.full  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/spgl_back.sv =====
`default_nettype none
module spgl_back
  import spgl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire item_t              item_i,
  input  wire queue_status_t      q_status_i,
  input  wire logic [BOOST_W-1:0] center_boost_i,
  input  wire logic               out_stall_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  output logic [GAIN_W-1:0]       gain_l_o,
  output logic [GAIN_W-1:0]       gain_r_o
);

  localparam int unsigned GW  = XW - 1;
  localparam int unsigned PW  = GW + BOOST_W;
  localparam int unsigned GMW = PW - 14;
  localparam int unsigned RW  = GMW + 1;
  localparam logic [RW-1:0] ONE = RW'(1) << GAIN_FRAC_BITS;
  localparam logic [RW-1:0] HALF = RW'(1) << (ANG_FRAC - 1 - GAIN_FRAC_BITS);

  logic en;

  logic                 v_q  [CORDIC_STEPS+1];
  logic                 cp_q [CORDIC_STEPS+1];
  logic                 bo_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] x_q  [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_q  [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q  [CORDIC_STEPS+1];

  logic                 mv_q;
  logic                 mcp_q;
  logic [GMW-1:0]       ml_q, mr_q;
  logic [GMW-1:0]       ml_d, mr_d;

  logic                 ov_q;
  logic [GAIN_W-1:0]    ol_q, or_q;
  logic [GAIN_W-1:0]    ol_d, or_d;

  assign en    = !ov_q || !out_stall_i;
  assign pop_o = en && !q_status_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= !q_status_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cp_q[0] <= item_i.cp;
      bo_q[0] <= item_i.boost;
      x_q[0]  <= item_i.x;
      y_q[0]  <= item_i.y;
      z_q[0]  <= item_i.z;
    end
  end

  for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_stage
    logic signed [XW-1:0] dx, dy;
    assign dx = y_q[k-1] >>> (k-1);
    assign dy = x_q[k-1] >>> (k-1);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cp_q[k] <= cp_q[k-1];
        bo_q[k] <= bo_q[k-1];
        if (!cp_q[k-1]) begin
          x_q[k] <= x_q[k-1];
          y_q[k] <= y_q[k-1];
          z_q[k] <= z_q[k-1];
        end else if (!z_q[k-1][ZW-1]) begin
          x_q[k] <= x_q[k-1] - dx;
          y_q[k] <= y_q[k-1] + dy;
          z_q[k] <= z_q[k-1] - atan_q30(k-1);
        end else begin
          x_q[k] <= x_q[k-1] + dx;
          y_q[k] <= y_q[k-1] - dy;
          z_q[k] <= z_q[k-1] + atan_q30(k-1);
        end
      end
    end
  end

  function automatic logic [GMW-1:0] boost_gain(input logic signed [XW-1:0] v,
                                                input logic bo,
                                                input logic [BOOST_W-1:0] cb);
    logic [GW-1:0] g;
    logic [PW-1:0] p;
    g = v[XW-1] ? '0 : v[GW-1:0];
    p = (PW'(g) * PW'(cb) + PW'(8192)) >> 14;
    return bo ? GMW'(p) : GMW'(g);
  endfunction

  function automatic logic [GAIN_W-1:0] round_gain(input logic [GMW-1:0] g);
    logic [RW-1:0] r;
    r = (RW'(g) + HALF) >> (ANG_FRAC - GAIN_FRAC_BITS);
    if (r > ONE) r = ONE;
    return r[GAIN_W-1:0];
  endfunction

  assign ml_d = boost_gain(x_q[CORDIC_STEPS], bo_q[CORDIC_STEPS], center_boost_i);
  assign mr_d = boost_gain(y_q[CORDIC_STEPS], bo_q[CORDIC_STEPS], center_boost_i);
  assign ol_d = mcp_q ? round_gain(ml_q) : ml_q[GAIN_W-1:0];
  assign or_d = mcp_q ? round_gain(mr_q) : mr_q[GAIN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      mv_q <= v_q[CORDIC_STEPS];
      ov_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mcp_q <= cp_q[CORDIC_STEPS];
      ml_q  <= ml_d;
      mr_q  <= mr_d;
      ol_q  <= ol_d;
      or_q  <= or_d;
    end
  end

  assign out_valid_o = ov_q;
  assign gain_l_o    = ol_q;
  assign gain_r_o    = or_q;

endmodule
`default_nettype wire
